// ===== rtl/core/palette_sprite_pixel_expander_defines.svh =====
// ----------------------------------------------------------------------------
// Palette sprite pixel expander: assertion macros
// Shared concurrent assertion forms used across the expander RTL.
// ----------------------------------------------------------------------------
`ifndef PALETTE_SPRITE_PIXEL_EXPANDER_DEFINES_SVH
`define PALETTE_SPRITE_PIXEL_EXPANDER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSPE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define PSPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pspe_pkg.sv =====
// ----------------------------------------------------------------------------
// pspe_pkg
// Types and constants shared by the palette sprite pixel expander.
// ----------------------------------------------------------------------------
package pspe_pkg;

   // Input item
   typedef struct packed {
      logic        opcode;
      logic [15:0] x_start;
      logic [15:0] y_start;
      logic [15:0] win_width;
      logic [15:0] win_height;
      logic [7:0]  pixel_byte;
   } req_type;

   // Result item
   typedef struct packed {
      logic        word_kind;
      logic [15:0] word_value;
      logic        run_last;
   } rsp_type;

   // Classified job handed from front to back
   typedef struct packed {
      logic        is_bitmap;
      logic        depth;
      logic [15:0] x_start;
      logic [15:0] x_end;
      logic [15:0] y_start;
      logic [15:0] y_end;
      logic [7:0]  pixel_byte;
   } job_type;

   typedef logic [3:0][15:0] palette_type;

   // Opcodes
   localparam logic OP_WINDOW = 1'b0;
   localparam logic OP_BITMAP = 1'b1;

   // Word kinds
   localparam logic KIND_CMD  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   // Pixel depth codes
   localparam logic DEPTH_1BPP = 1'b0;
   localparam logic DEPTH_2BPP = 1'b1;

   // Display controller commands
   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   // Register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_DEPTH = 3'd4;

   // Back-end word steps
   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] WIN_STEP_COL_CMD  = 4'd0;
   localparam logic [STEP_W-1:0] WIN_STEP_X_START  = 4'd1;
   localparam logic [STEP_W-1:0] WIN_STEP_X_END    = 4'd2;
   localparam logic [STEP_W-1:0] WIN_STEP_PAGE_CMD = 4'd3;
   localparam logic [STEP_W-1:0] WIN_STEP_Y_START  = 4'd4;
   localparam logic [STEP_W-1:0] WIN_STEP_Y_END    = 4'd5;
   localparam logic [STEP_W-1:0] WIN_STEP_MEM_CMD  = 4'd6;
   localparam logic [STEP_W-1:0] BPP1_LAST_STEP    = 4'd15;
   localparam logic [STEP_W-1:0] BPP2_LAST_STEP    = 4'd7;

endpackage

// ===== rtl/core/palette_sprite_pixel_expander.sv =====
// ----------------------------------------------------------------------------
// palette_sprite_pixel_expander
// Sprite window and bitmap bytes in, display controller words out.
//
//   Channel   Dir  Handshake              Payload
//   req_      in   req_valid/req_ready    req_type  (opcode, window, byte)
//   rsp_      out  rsp_valid/rsp_ready    rsp_type  (kind, value, last)
//   csr_      in   csr_wr_en              csr_index, csr_wr_data
//
// One word leaves per cycle from the back-end output register while rsp_ready
// is high: a window item gives 7 words, a bitmap byte 16 (1 bpp) or 8 (2 bpp).
// Items enter while earlier ones are still expanding, held in a queue of
// QUEUE_DEPTH jobs; req_ready drops only when that queue is full.
// Reset clears control and CSR state, not data; the block is ready the cycle after.
// rsp_ready low holds the output word; the queue then fills behind it.
// ----------------------------------------------------------------------------
module palette_sprite_pixel_expander #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pspe_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pspe_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [pspe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                  csr_wr_data
);
   import pspe_pkg::*;

   palette_type palette_ff, palette_in;
   logic        depth_ff, depth_in;
   logic        push, pop, full, empty;
   job_type     push_job, head_job;

   // Configuration registers
   always_comb begin
      palette_in = palette_ff;
      depth_in   = depth_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PALETTE_0:   palette_in[0] = csr_wr_data;
            CSR_PALETTE_1:   palette_in[1] = csr_wr_data;
            CSR_PALETTE_2:   palette_in[2] = csr_wr_data;
            CSR_PALETTE_3:   palette_in[3] = csr_wr_data;
            CSR_PIXEL_DEPTH: depth_in      = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= '0;
         depth_ff   <= DEPTH_2BPP;
      end else begin
         palette_ff <= palette_in;
         depth_ff   <= depth_in;
      end
   end

   // Front: accept and classify
   pspe_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .pixel_depth (depth_ff),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   // Job queue
   pspe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head_job (head_job)
   );

   // Back: word sequencing
   pspe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!empty),
      .job       (head_job),
      .palette   (palette_ff),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/pspe_front.sv =====
// ----------------------------------------------------------------------------
// pspe_front
// Accepts input items, classifies them and precomputes window end points.
// ----------------------------------------------------------------------------
module pspe_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  pspe_pkg::req_type req_data,
   input  logic             pixel_depth,
   input  logic             queue_full,
   output logic             push,
   output pspe_pkg::job_type push_job
);
   import pspe_pkg::*;

   // Take an item whenever the queue has room
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // Classify and compute end coordinates (wrap at 16 bits)
   always_comb begin
      push_job            = '0;
      push_job.is_bitmap  = (req_data.opcode == OP_BITMAP);
      push_job.depth      = pixel_depth;
      push_job.x_start    = req_data.x_start;
      push_job.x_end      = 16'(req_data.x_start + req_data.win_width - 16'd1);
      push_job.y_start    = req_data.y_start;
      push_job.y_end      = 16'(req_data.y_start + req_data.win_height - 16'd1);
      push_job.pixel_byte = req_data.pixel_byte;
   end

endmodule

// ===== rtl/core/pspe_queue.sv =====
`include "palette_sprite_pixel_expander_defines.svh"
// ----------------------------------------------------------------------------
// pspe_queue
// Short register queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module pspe_queue #(
   parameter int unsigned DEPTH = 2   // 2 and up
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pspe_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output pspe_pkg::job_type head_job
);
   import pspe_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Checks
   `PSPE_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !full, "push into full queue")
   `PSPE_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, !empty, "pop from empty queue")
   `PSPE_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == CNT_W'($past(count_ff) + 1'b1), "count lost a push")

endmodule

// ===== rtl/core/pspe_back.sv =====
`include "palette_sprite_pixel_expander_defines.svh"
// ----------------------------------------------------------------------------
// pspe_back
// Steps through the head job one word per cycle, while the output register is
// empty or being drained, into the output register.
module pspe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  pspe_pkg::job_type     job,
   input  pspe_pkg::palette_type palette,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pspe_pkg::rsp_type     rsp_data
);
   import pspe_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              load;
   logic [STEP_W-1:0] last_step;
   logic              is_last;
   logic [7:0]        shifted;
   logic [1:0]        code;

   // Output register takes a word when empty or being drained
   assign load      = job_valid && (!rsp_valid_ff || rsp_ready);
   assign last_step = !job.is_bitmap ? WIN_STEP_MEM_CMD :
                      (job.depth == DEPTH_2BPP) ? BPP2_LAST_STEP : BPP1_LAST_STEP;
   assign is_last   = (step_ff == last_step);
   assign pop       = load && is_last;

   // Pixel code: step[3:1] (1 bpp) or step[2:1] (2 bpp) is the pixel, each sent twice
   always_comb begin
      if (job.depth == DEPTH_2BPP) begin
         shifted = job.pixel_byte << {step_ff[2:1], 1'b0};
         code    = shifted[7:6];
      end else begin
         shifted = job.pixel_byte << step_ff[3:1];
         code    = {1'b0, shifted[7]};
      end
   end

   // Word select
   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in.run_last = is_last;
      if (job.is_bitmap) begin
         rsp_data_in.word_kind  = KIND_DATA;
         rsp_data_in.word_value = palette[code];
      end else begin
         case (step_ff)
            WIN_STEP_COL_CMD: begin
               rsp_data_in.word_kind  = KIND_CMD;
               rsp_data_in.word_value = {8'h00, CMD_COLUMN_SET};
            end
            WIN_STEP_X_START: begin
               rsp_data_in.word_kind  = KIND_DATA;
               rsp_data_in.word_value = job.x_start;
            end
            WIN_STEP_X_END: begin
               rsp_data_in.word_kind  = KIND_DATA;
               rsp_data_in.word_value = job.x_end;
            end
            WIN_STEP_PAGE_CMD: begin
               rsp_data_in.word_kind  = KIND_CMD;
               rsp_data_in.word_value = {8'h00, CMD_PAGE_SET};
            end
            WIN_STEP_Y_START: begin
               rsp_data_in.word_kind  = KIND_DATA;
               rsp_data_in.word_value = job.y_start;
            end
            WIN_STEP_Y_END: begin
               rsp_data_in.word_kind  = KIND_DATA;
               rsp_data_in.word_value = job.y_end;
            end
            default: begin
               rsp_data_in.word_kind  = KIND_CMD;
               rsp_data_in.word_value = {8'h00, CMD_MEMORY_WRITE};
            end
         endcase
      end
   end

   // Step counter and output valid
   always_comb begin
      step_in = step_ff;
      if (pop) begin
         step_in = '0;
      end else if (load) begin
         step_in = step_ff + 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `PSPE_ASSERT_IMPLY(a_win_step_range, clock, reset, job_valid && !job.is_bitmap, step_ff <= WIN_STEP_MEM_CMD, "window step out of range")
   `PSPE_ASSERT_NEXT(a_step_restart, clock, reset, pop, step_ff == '0, "step not restarted after job")
   `PSPE_ASSERT_NEXT(a_last_flag, clock, reset, load, rsp_valid_ff && (rsp_data_ff.run_last == $past(is_last)), "run_last mismatch")

endmodule
